// ===== hdl/ntc_pkg.sv =====
`timescale 1ns / 1ps

package ntc_pkg;

    localparam int ADC_BITS     = 12;
    localparam int TABLE_POINTS = 34;
    localparam int NUM_SEGS     = TABLE_POINTS - 1;

    localparam int TEMP_W       = 18;
    localparam int OFF_W        = 8;
    localparam int RECIP_SHIFT  = 8;
    localparam int RECIP_W      = 16;
    localparam int QUOT_W       = 13;
    localparam int NUM_W        = 20;
    localparam int PROD_W       = OFF_W + RECIP_W;

    localparam int STEP_MILLI_C = 5000;
    localparam int TEMP_BASE    = -40000;
    localparam int TEMP_MAX     = 125000;
    localparam int RECIP_NUM    = STEP_MILLI_C << RECIP_SHIFT;

    // divider codes, cold end first, falling with temperature
    localparam logic [ADC_BITS-1:0] NTC_CODE [TABLE_POINTS] = '{
        12'd3928, 12'd3872, 12'd3802, 12'd3716, 12'd3613, 12'd3492, 12'd3353, 12'd3196,
        12'd3024, 12'd2839, 12'd2644, 12'd2445, 12'd2245, 12'd2048, 12'd1857, 12'd1675,
        12'd1505, 12'd1347, 12'd1203, 12'd1072, 12'd954,  12'd849,  12'd755,  12'd672,
        12'd598,  12'd533,  12'd476,  12'd425,  12'd380,  12'd341,  12'd306,  12'd276,
        12'd249,  12'd224
    };

    // floor(5000 * 256 / span) for each segment
    localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_SEGS] = '{
        RECIP_W'(RECIP_NUM / 56),  RECIP_W'(RECIP_NUM / 70),  RECIP_W'(RECIP_NUM / 86),
        RECIP_W'(RECIP_NUM / 103), RECIP_W'(RECIP_NUM / 121), RECIP_W'(RECIP_NUM / 139),
        RECIP_W'(RECIP_NUM / 157), RECIP_W'(RECIP_NUM / 172), RECIP_W'(RECIP_NUM / 185),
        RECIP_W'(RECIP_NUM / 195), RECIP_W'(RECIP_NUM / 199), RECIP_W'(RECIP_NUM / 200),
        RECIP_W'(RECIP_NUM / 197), RECIP_W'(RECIP_NUM / 191), RECIP_W'(RECIP_NUM / 182),
        RECIP_W'(RECIP_NUM / 170), RECIP_W'(RECIP_NUM / 158), RECIP_W'(RECIP_NUM / 144),
        RECIP_W'(RECIP_NUM / 131), RECIP_W'(RECIP_NUM / 118), RECIP_W'(RECIP_NUM / 105),
        RECIP_W'(RECIP_NUM / 94),  RECIP_W'(RECIP_NUM / 83),  RECIP_W'(RECIP_NUM / 74),
        RECIP_W'(RECIP_NUM / 65),  RECIP_W'(RECIP_NUM / 57),  RECIP_W'(RECIP_NUM / 51),
        RECIP_W'(RECIP_NUM / 45),  RECIP_W'(RECIP_NUM / 39),  RECIP_W'(RECIP_NUM / 35),
        RECIP_W'(RECIP_NUM / 30),  RECIP_W'(RECIP_NUM / 27),  RECIP_W'(RECIP_NUM / 25)
    };

    typedef struct packed {
        logic                     in_range;
        logic signed [TEMP_W-1:0] t_hi;
        logic [OFF_W-1:0]         offset;
        logic [OFF_W-1:0]         span;
        logic [RECIP_W-1:0]       recip;
    } seg_t;

endpackage

// ===== hdl/ntc_raw_to_temperature.sv =====
`timescale 1ns / 1ps

// Converts one 12-bit NTC divider ADC code per item to millidegrees Celsius by
// linear interpolation over a 34-point table (-40 C to 125 C in 5 C steps).
// Codes above 3928 or below 224 give m_valid_res low and a temperature of 0.
// The converter is a five-stage pipeline: table compare, segment select, reciprocal
// multiply, quotient correction and final add. It takes one item every cycle
// while m_ready stays high; the per-segment divide is a reciprocal multiply with
// a single correction step. Stages hold independently under back-pressure, so
// bubbles in the pipeline fill while a finished item waits on the output.
module ntc_raw_to_temperature (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ntc_pkg::ADC_BITS-1:0]      s_raw_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ntc_pkg::TEMP_W-1:0] m_temperature_milli_c,
    output logic                              m_valid_res
);
    import ntc_pkg::*;

    logic seg_valid;
    logic seg_ready;
    seg_t seg;

    ntc_seg_find u_seg_find (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_raw_sample (s_raw_sample),
        .seg_valid    (seg_valid),
        .seg_ready    (seg_ready),
        .seg          (seg)
    );

    ntc_interp u_interp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .seg_valid             (seg_valid),
        .seg_ready             (seg_ready),
        .seg                   (seg),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_temperature_milli_c (m_temperature_milli_c),
        .m_valid_res           (m_valid_res)
    );

endmodule

// ===== hdl/ntc_seg_find.sv =====
`timescale 1ns / 1ps

module ntc_seg_find (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ntc_pkg::ADC_BITS-1:0] s_raw_sample,
    output logic                         seg_valid,
    input  logic                         seg_ready,
    output ntc_pkg::seg_t                seg
);
    import ntc_pkg::*;

    // stage 1: compares against every table point
    logic                v1_reg, v1_next;
    logic [ADC_BITS-1:0] code1_reg;
    logic [NUM_SEGS-1:0] below1_reg, below1_next;
    logic                range1_reg, range1_next;

    // stage 2: segment selected, table values fetched
    logic                v2_reg, v2_next;
    seg_t                seg2_reg, seg2_next;

    logic                ready1, ready2;
    logic [NUM_SEGS-1:0] first;
    logic [ADC_BITS-1:0] hi_sel;
    logic [OFF_W-1:0]    span_sel;
    logic [RECIP_W-1:0]  recip_sel;
    logic [TEMP_W-1:0]   thi_sel;

    assign ready2  = !v2_reg || seg_ready;
    assign ready1  = !v1_reg || ready2;
    assign s_ready = ready1;

    always_comb begin
        for (int i = 0; i < NUM_SEGS; i++) begin
            below1_next[i] = s_raw_sample < NTC_CODE[i+1];
        end
        range1_next = (s_raw_sample <= NTC_CODE[0]) &&
                      (s_raw_sample >= NTC_CODE[TABLE_POINTS-1]);
        v1_next = ready1 ? s_valid : v1_reg;
    end

    // below is a run of ones from the cold end, the segment is its first zero
    assign first = ~below1_reg & {below1_reg[NUM_SEGS-2:0], 1'b1};

    always_comb begin
        hi_sel    = '0;
        span_sel  = '0;
        recip_sel = '0;
        thi_sel   = '0;
        for (int i = 0; i < NUM_SEGS; i++) begin
            hi_sel    = hi_sel    | ({ADC_BITS{first[i]}} & NTC_CODE[i]);
            span_sel  = span_sel  | ({OFF_W{first[i]}} &
                                     OFF_W'(NTC_CODE[i] - NTC_CODE[i+1]));
            recip_sel = recip_sel | ({RECIP_W{first[i]}} & SEG_RECIP[i]);
            thi_sel   = thi_sel   | ({TEMP_W{first[i]}} &
                                     TEMP_W'(TEMP_BASE + i * STEP_MILLI_C));
        end
        seg2_next.in_range = range1_reg;
        seg2_next.t_hi     = range1_reg ? signed'(thi_sel) : '0;
        seg2_next.offset   = range1_reg ? OFF_W'(hi_sel - code1_reg) : '0;
        seg2_next.span     = span_sel;
        seg2_next.recip    = range1_reg ? recip_sel : '0;
        v2_next = ready2 ? v1_reg : v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && s_valid) begin
            code1_reg  <= s_raw_sample;
            below1_reg <= below1_next;
            range1_reg <= range1_next;
        end
        if (ready2 && v1_reg) begin
            seg2_reg <= seg2_next;
        end
    end

    assign seg_valid = v2_reg;
    assign seg       = seg2_reg;

    a_range_has_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && range1_reg) |-> !below1_reg[NUM_SEGS-1])
        else $error("in-range code found no segment");

    a_offset_in_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && seg2_reg.in_range) |-> (seg2_reg.offset <= seg2_reg.span))
        else $error("offset beyond segment span");

endmodule

// ===== hdl/ntc_interp.sv =====
`timescale 1ns / 1ps

module ntc_interp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              seg_valid,
    output logic                              seg_ready,
    input  ntc_pkg::seg_t                     seg,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ntc_pkg::TEMP_W-1:0] m_temperature_milli_c,
    output logic                              m_valid_res
);
    import ntc_pkg::*;

    // stage 3: reciprocal product and numerator
    logic                     v3_reg, v3_next;
    logic                     range3_reg;
    logic signed [TEMP_W-1:0] thi3_reg;
    logic [OFF_W-1:0]         span3_reg;
    logic [QUOT_W-1:0]        qest3_reg;
    logic [NUM_W-1:0]         num3_reg;

    // stage 4: corrected quotient
    logic                     v4_reg, v4_next;
    logic                     range4_reg;
    logic signed [TEMP_W-1:0] thi4_reg;
    logic [QUOT_W-1:0]        q4_reg, q4_next;

    // stage 5: output register
    logic                     v5_reg, v5_next;
    logic signed [TEMP_W-1:0] temp5_reg, temp5_next;
    logic                     range5_reg;

    logic                     ready3, ready4, ready5;
    logic [PROD_W-1:0]        prod;
    logic [NUM_W-1:0]         num;
    logic [QUOT_W-1:0]        qp1;
    logic [NUM_W-1:0]         chk;

    assign ready5    = !v5_reg || m_ready;
    assign ready4    = !v4_reg || ready5;
    assign ready3    = !v3_reg || ready4;
    assign seg_ready = ready3;

    always_comb begin
        prod    = PROD_W'(seg.offset) * PROD_W'(seg.recip);
        num     = NUM_W'(seg.offset) * NUM_W'(STEP_MILLI_C);
        v3_next = ready3 ? seg_valid : v3_reg;
    end

    // estimate is exact or one short
    always_comb begin
        qp1     = qest3_reg + QUOT_W'(1);
        chk     = NUM_W'(qp1) * NUM_W'(span3_reg);
        q4_next = (chk <= num3_reg) ? qp1 : qest3_reg;
        v4_next = ready4 ? v3_reg : v4_reg;
    end

    always_comb begin
        temp5_next = range4_reg ? (thi4_reg + signed'(TEMP_W'(q4_reg))) : '0;
        v5_next    = ready5 ? v4_reg : v5_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready3 && seg_valid) begin
            range3_reg <= seg.in_range;
            thi3_reg   <= seg.t_hi;
            span3_reg  <= seg.span;
            qest3_reg  <= prod[RECIP_SHIFT +: QUOT_W];
            num3_reg   <= num;
        end
        if (ready4 && v3_reg) begin
            range4_reg <= range3_reg;
            thi4_reg   <= thi3_reg;
            q4_reg     <= q4_next;
        end
        if (ready5 && v4_reg) begin
            range5_reg <= range4_reg;
            temp5_reg  <= temp5_next;
        end
    end

    assign m_valid               = v5_reg;
    assign m_temperature_milli_c = temp5_reg;
    assign m_valid_res           = range5_reg;

    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && range4_reg) |-> (q4_reg <= QUOT_W'(STEP_MILLI_C)))
        else $error("quotient exceeds one step");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (v5_reg && !range5_reg) |-> (temp5_reg == '0))
        else $error("out-of-range item with non-zero temperature");

    a_temp_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (v5_reg && range5_reg) |->
            ((temp5_reg >= TEMP_W'(TEMP_BASE)) && (temp5_reg <= TEMP_W'(TEMP_MAX))))
        else $error("temperature outside table range");

endmodule

// ===== tb/sv/ntc_raw_to_temperature_tb.sv =====
`timescale 1ns / 1ps

module ntc_raw_to_temperature_tb;

    import ntc_pkg::*;

    localparam int N_POINTS       = 34;
    localparam int N_SEGMENTS     = N_POINTS - 1;
    localparam int COLD_MILLI_C   = -40000;
    localparam int STEP_MILLI_C_T = 5000;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 20;

    localparam int POINT_CODE [N_POINTS] = '{
        3928, 3872, 3802, 3716, 3613, 3492, 3353, 3196,
        3024, 2839, 2644, 2445, 2245, 2048, 1857, 1675,
        1505, 1347, 1203, 1072,  954,  849,  755,  672,
         598,  533,  476,  425,  380,  341,  306,  276,
         249,  224
    };

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     ok;
    } reading_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [ADC_BITS-1:0]      s_raw_sample = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [TEMP_W-1:0] m_temperature_milli_c;
    logic                     m_valid_res;

    reading_t readings_pending [$];

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int rx_hold = 0;
    int cycles = 0;
    int mismatches = 0;
    int samples_sent = 0;
    int readings_checked = 0;
    int in_range_seen = 0;
    int out_range_seen = 0;

    ntc_raw_to_temperature DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_raw_sample          (s_raw_sample),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_temperature_milli_c (m_temperature_milli_c),
        .m_valid_res           (m_valid_res)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d readings outstanding", cycles,
                     readings_pending.size());
            $display("ntc_raw_to_temperature_tb: done, errors");
            $finish;
        end
    end

    function automatic reading_t convert_sample(logic [ADC_BITS-1:0] code);
        reading_t r;
        int       c;
        int       span;
        int       offset;
        int       t_hi;
        r.temp = '0;
        r.ok   = 1'b0;
        c      = int'(code);
        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            if (!r.ok && c <= POINT_CODE[seg] && c >= POINT_CODE[seg+1]) begin
                span   = POINT_CODE[seg] - POINT_CODE[seg+1];
                offset = POINT_CODE[seg] - c;
                t_hi   = COLD_MILLI_C + STEP_MILLI_C_T * seg;
                if (span > 0) begin
                    r.temp = TEMP_W'(t_hi + (STEP_MILLI_C_T * offset) / span);
                    r.ok   = 1'b1;
                end
                else begin
                    // empty segment stops the search, reading stays invalid
                    seg = N_SEGMENTS;
                end
            end
        end
        return r;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 24);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch @%0d: %s", cycles, msg);
        mismatches++;
    endtask

    // one item per call, entered and left on a rising edge
    task automatic send_sample(logic [ADC_BITS-1:0] code);
        int gap;
        gap = tx_idle_on ? idle_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_raw_sample <= code;
        do @(posedge aclk); while (!s_ready);
        readings_pending.push_back(convert_sample(code));
        samples_sent++;
    endtask

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (readings_pending.size() == 0) begin
                report_mismatch($sformatf("unexpected reading %0d valid %0b",
                                          m_temperature_milli_c, m_valid_res));
            end
            else begin
                want = readings_pending.pop_front();
                readings_checked++;
                if (want.ok)
                    in_range_seen++;
                else
                    out_range_seen++;
                if (m_temperature_milli_c !== want.temp)
                    report_mismatch($sformatf("temperature %0d, want %0d",
                                              m_temperature_milli_c, want.temp));
                if (m_valid_res !== want.ok)
                    report_mismatch($sformatf("valid_res %0b, want %0b",
                                              m_valid_res, want.ok));
            end
        end
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end
        else begin
            m_ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 3) == 0)
                rx_hold = idle_length();
        end
    end

    task automatic test_range_edges();
        int codes [$];
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        codes = '{0, 4095, 1, 4094, 223, 224, 225, 3927, 3928, 3929, 3872, 3024,
                  2048, 1505, 954, 380, 249, 2946, 2730, 1365, 2047, 3900, 250};
        foreach (codes[i])
            send_sample(ADC_BITS'(codes[i]));
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (60) send_sample(ADC_BITS'($urandom_range(0, 4095)));
    endtask

    task automatic test_random_in_range();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (300) send_sample(ADC_BITS'($urandom_range(224, 3928)));
    endtask

    task automatic test_table_neighbourhood();
        int pt;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        repeat (100) begin
            pt = $urandom_range(0, N_POINTS - 1);
            send_sample(ADC_BITS'(POINT_CODE[pt] + $urandom_range(0, 4) - 2));
        end
    endtask

    task automatic test_random_full_range();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        repeat (90) send_sample(ADC_BITS'($urandom_range(0, 4095)));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_range_edges();
        test_back_to_back();
        test_random_in_range();
        test_table_neighbourhood();
        test_random_full_range();

        s_valid <= 1'b0;
        rx_idle_on = 1'b1;
        while (readings_pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d samples sent, %0d readings checked", samples_sent, readings_checked);
        $display("%0d within the table, %0d out of range", in_range_seen, out_range_seen);
        if (mismatches == 0) begin
            $display("ntc_raw_to_temperature_tb: done, clean");
        end
        else begin
            $display("%0d mismatches", mismatches);
            $display("ntc_raw_to_temperature_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== ntc_raw_to_temperature.f =====
hdl/ntc_pkg.sv
hdl/ntc_seg_find.sv
hdl/ntc_interp.sv
hdl/ntc_raw_to_temperature.sv
tb/sv/ntc_raw_to_temperature_tb.sv
